>>> rtl/core/depth_to_point_cloud_defines.svh
// Assertion macros shared by the depth-to-point-cloud RTL.
// Both macros sample on clk_i; the first is gated by rst_ni, the second
// also holds through reset.
`ifndef DEPTH_TO_POINT_CLOUD_DEFINES_SVH
`define DEPTH_TO_POINT_CLOUD_DEFINES_SVH

`ifndef SYNTHESIS

`define DPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

`define DPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");

`else

`define DPC_ASSERT(lbl, prop)

`define DPC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/dpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CNT_W      = 12;
  localparam int DIM_W      = 13;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DLIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd6;

  // Depth marker for a missing measurement
  localparam logic [15:0] NO_DEPTH = 16'hFFFF;

  // Divide by 1000: shift right by 3, then divide by 125 with a multiply.
  // (n * RECIP_125) >> RECIP_SH equals n / 125 for every n below 2^32.
  localparam int          RECIP_SH  = 38;
  localparam logic [31:0] RECIP_125 = 32'd2199023256;

  // Coordinate product and rounding: x = round(prod / 4096000)
  localparam int PROD_W = 56;
  localparam int TQ_W   = 45;
  localparam logic [PROD_W:0]  XY_HALF    = 57'd2048000;
  localparam logic [TQ_W-1:0]  XY_DIV_MAX = 45'd16777216000;
  localparam logic [31:0]      Z_HALF     = 32'd500;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic load_div;
    logic div_mul;
    logic load_out;
  } dpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic keep;
    logic out_free;
  } dpc_status_t;

endpackage

`default_nettype wire

>>> rtl/core/dpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dpc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel in
  input  wire logic [15:0]                   depth_mm_i,
  input  wire logic                          frame_start_i,
  // point out
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [23:0]                 point_x_o,
  output logic signed [23:0]                 point_y_o,
  output logic [22:0]                        point_z_o,
  output logic [11:0]                        pixel_col_o,
  output logic [11:0]                        pixel_row_o,
  // control
  input  wire dpc_pkg::dpc_cmd_t             cmd_i,
  output dpc_pkg::dpc_status_t               stat_o
);
  import dpc_pkg::*;

  // Configuration registers
  logic [23:0] inv_fx_q, inv_fy_q;
  logic [15:0] cx_q, cy_q;
  logic [16:0] dlimit_q;
  logic [DIM_W-1:0] fwidth_q, fheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q  <= 24'd24935;
      inv_fy_q  <= 24'd24938;
      cx_q      <= 16'd6392;
      cy_q      <= 16'd4810;
      dlimit_q  <= 17'd65536;
      fwidth_q  <= 13'd800;
      fheight_q <= 13'd592;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INV_FX:   inv_fx_q  <= cfg_data_i;
        CFG_INV_FY:   inv_fy_q  <= cfg_data_i;
        CFG_CENTER_X: cx_q      <= cfg_data_i[15:0];
        CFG_CENTER_Y: cy_q      <= cfg_data_i[15:0];
        CFG_DLIMIT:   dlimit_q  <= cfg_data_i[16:0];
        CFG_WIDTH:    fwidth_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:   fheight_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Position counters
  logic [CNT_W-1:0] col_cnt_q, row_cnt_q, col_cnt_d, row_cnt_d;
  logic [CNT_W-1:0] col_cur, row_cur;
  logic [DIM_W-1:0] col_inc, row_inc, w_eff, h_eff;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_cnt_q;
    row_cur = frame_start_i ? '0 : row_cnt_q;
    w_eff = (fwidth_q == '0 || fwidth_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fwidth_q;
    h_eff = (fheight_q == '0 || fheight_q > DIM_W'(MAX_HEIGHT)) ?
            DIM_W'(MAX_HEIGHT) : fheight_q;
    col_inc = {1'b0, col_cur} + DIM_W'(1);
    row_inc = {1'b0, row_cur} + DIM_W'(1);
    col_cnt_d = col_inc[CNT_W-1:0];
    row_cnt_d = row_cur;
    if (col_inc >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Drop test on the pixel being offered
  logic keep_c;
  assign keep_c = (depth_mm_i != NO_DEPTH) && ({1'b0, depth_mm_i} < dlimit_q);

  // Offsets from the principal point, Q12.4
  logic [15:0] p16x, p16y;
  logic        negx_c, negy_c;
  assign p16x   = {col_cur, 4'b0000};
  assign p16y   = {row_cur, 4'b0000};
  assign negx_c = p16x < cx_q;
  assign negy_c = p16y < cy_q;

  logic [15:0] depth_q, magx_q, magy_q;
  logic [11:0] col_q, row_q;
  logic        negx_q, negy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      depth_q <= depth_mm_i;
      col_q   <= col_cur;
      row_q   <= row_cur;
      negx_q  <= negx_c;
      negy_q  <= negy_c;
      magx_q  <= negx_c ? (cx_q - p16x) : (p16x - cx_q);
      magy_q  <= negy_c ? (cy_q - p16y) : (p16y - cy_q);
    end
  end

  // Two multiply stages: offset * 1/f, then * depth
  logic [39:0]       px1_q, py1_q;
  logic [PROD_W-1:0] px2_q, py2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      px1_q <= 40'(magx_q) * 40'(inv_fx_q);
      py1_q <= 40'(magy_q) * 40'(inv_fy_q);
    end
    if (cmd_i.mul2) begin
      px2_q <= PROD_W'(px1_q) * PROD_W'(depth_q);
      py2_q <= PROD_W'(py1_q) * PROD_W'(depth_q);
    end
  end

  // Round term added, divide by 4096 as a shift; the /1000 follows
  logic [PROD_W:0] sumx, sumy;
  logic [TQ_W-1:0] tx, ty;
  logic [31:0]     zdiv;
  assign sumx = {1'b0, px2_q} + XY_HALF;
  assign sumy = {1'b0, py2_q} + XY_HALF;
  assign tx   = sumx[PROD_W:12];
  assign ty   = sumy[PROD_W:12];
  assign zdiv = {depth_q, 16'h0000} + Z_HALF;

  // Divide by 1000: drop three bits on load, then a reciprocal multiply by 1/125
  logic [31:0] nx_q, ny_q, nz_q;
  logic [23:0] qx_q, qy_q, qz_q;
  logic        bigx_q, bigy_q;
  logic [63:0] mx, my, mz;

  assign mx = 64'(nx_q) * 64'(RECIP_125);
  assign my = 64'(ny_q) * 64'(RECIP_125);
  assign mz = 64'(nz_q) * 64'(RECIP_125);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      bigx_q <= tx >= XY_DIV_MAX;
      bigy_q <= ty >= XY_DIV_MAX;
      nx_q   <= {1'b0, tx[33:3]};
      ny_q   <= {1'b0, ty[33:3]};
      nz_q   <= {3'b000, zdiv[31:3]};
    end
    if (cmd_i.div_mul) begin
      qx_q <= mx[RECIP_SH+23:RECIP_SH];
      qy_q <= my[RECIP_SH+23:RECIP_SH];
      qz_q <= mz[RECIP_SH+23:RECIP_SH];
    end
  end

  // Sign and saturation
  logic [23:0] x_res, y_res;

  always_comb begin
    if (negx_q) begin
      x_res = (bigx_q || qx_q > 24'h800000) ? 24'h800000 : (24'd0 - qx_q);
    end else begin
      x_res = (bigx_q || qx_q[23]) ? 24'h7FFFFF : qx_q;
    end
    if (negy_q) begin
      y_res = (bigy_q || qy_q > 24'h800000) ? 24'h800000 : (24'd0 - qy_q);
    end else begin
      y_res = (bigy_q || qy_q[23]) ? 24'h7FFFFF : qy_q;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      point_x_o   <= x_res;
      point_y_o   <= y_res;
      point_z_o   <= qz_q[22:0];
      pixel_col_o <= col_q;
      pixel_row_o <= row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign stat_o      = '{keep: keep_c, out_free: !out_valid_q || out_ready_i};

endmodule

`default_nettype wire

>>> rtl/core/dpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "depth_to_point_cloud_defines.svh"

module dpc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dpc_pkg::dpc_status_t stat_i,
  output dpc_pkg::dpc_cmd_t         cmd_o
);
  import dpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencing and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && stat_i.keep) state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_div = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_mul = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A kept pixel starts the multiply chain next cycle
  `DPC_ASSERT(a_keep_starts, (cmd_o.accept && stat_i.keep) |=> (state_q == S_MUL1))
  // A result is never loaded over one still waiting
  `DPC_ASSERT(a_load_free, cmd_o.load_out |-> stat_i.out_free)
  // The rounding load is followed by the divide
  `DPC_ASSERT(a_load_div, (state_q == S_LOAD) |=> (state_q == S_DIV))
  // The divide is followed directly by the state that forms the result
  `DPC_ASSERT(a_div_done, (state_q == S_DIV) |=> (state_q == S_DONE))
  // Only one command of the datapath pipeline at a time
  `DPC_ASSERT_ALWAYS(a_cmd_onehot,
    $onehot0({cmd_o.mul1, cmd_o.mul2, cmd_o.load_div, cmd_o.div_mul, cmd_o.load_out}))

endmodule

`default_nettype wire

>>> rtl/core/depth_to_point_cloud.sv
// Channel | Direction | Handshake              | Payload
// pixel   | in        | in_valid_i/in_ready_o   | depth_mm_i, frame_start_i
// point   | out       | out_valid_o/out_ready_i | point_x/y/z_o, pixel_col_o, pixel_row_o
// config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A dropped pixel is done at its accept; a kept pixel goes through accept, two
// multiply stages, rounding load, reciprocal divide by 1000 and output load.
// The input is ready again the cycle after the result is registered.
// Reset clears the counters, controller and output valid; configuration
// returns to its reset values. A stalled output holds its result and
// blocks the next kept pixel only at its final load.
`timescale 1ns / 1ps
`default_nettype none

module depth_to_point_cloud (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [15:0]                    depth_mm_i,
  input  wire logic                           frame_start_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [23:0]                  point_x_o,
  output logic signed [23:0]                  point_y_o,
  output logic [22:0]                         point_z_o,
  output logic [11:0]                         pixel_col_o,
  output logic [11:0]                         pixel_row_o
);
  import dpc_pkg::*;

  dpc_cmd_t    cmd;
  dpc_status_t stat;

  // Registers accept a write at any cycle
  assign cfg_ready_o = 1'b1;

  dpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .depth_mm_i    (depth_mm_i),
    .frame_start_i (frame_start_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // Timing and run length
  localparam int CLK_HALF       = 6;
  localparam int RST_CYCLES     = 9;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_ITEM_GOAL = 446;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_REPORTS    = 10;
  localparam int DIM_MAX        = 4096;

  // Fixed-point constants of the projection
  localparam longint unsigned XY_DIVISOR = 64'd4096000;
  localparam longint unsigned XY_ROUND   = 64'd2048000;
  localparam longint unsigned MM_PER_M   = 64'd1000;
  localparam longint unsigned Z_ROUND    = 64'd500;
  localparam longint unsigned SAT_POS    = 64'd8388607;
  localparam longint unsigned SAT_NEG    = 64'd8388608;

  // Index past the register list, writes to it must be ignored
  localparam logic [dpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0] depth;
    logic        start;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [22:0]        z;
    logic [11:0]        col;
    logic [11:0]        row;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_ready_o;
  logic [15:0]                     depth_mm_i    = '0;
  logic                            frame_start_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i   = 1'b0;
  logic signed [23:0]              point_x_o;
  logic signed [23:0]              point_y_o;
  logic [22:0]                     point_z_o;
  logic [11:0]                     pixel_col_o;
  logic [11:0]                     pixel_row_o;

  depth_to_point_cloud dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .depth_mm_i    (depth_mm_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Pixels waiting to be offered, points waiting to come out
  pixel_t pixel_q[$];
  point_t point_q[$];

  // Mirror of the block's registers and raster position
  logic [23:0] fx_inv  = 24'd24935;
  logic [23:0] fy_inv  = 24'd24938;
  logic [15:0] cx_q4   = 16'd6392;
  logic [15:0] cy_q4   = 16'd4810;
  logic [16:0] z_limit = 17'd65536;
  logic [12:0] fw      = 13'd800;
  logic [12:0] fh      = 13'd592;
  logic [11:0] col_pos = '0;
  logic [11:0] row_pos = '0;

  int  fail_count = 0;
  int  cycle_cnt  = 0;
  int  rand_items = 0;
  logic hold_arm  = 1'b0;

  function automatic int eff_dim(input logic [12:0] d);
    return (d == 13'd0 || d > 13'(DIM_MAX)) ? DIM_MAX : int'(d);
  endfunction

  function automatic bit is_kept(input logic [15:0] depth);
    return depth != dpc_pkg::NO_DEPTH && {1'b0, depth} < z_limit;
  endfunction

  // One axis: (16*pos - center) * inv * depth / 4096000, rounded to nearest, halves away from zero
  function automatic logic signed [23:0] back_project(input logic [11:0] pos,
                                                      input logic [15:0] ctr,
                                                      input logic [23:0] inv,
                                                      input logic [15:0] depth);
    longint unsigned p16, mag, q;
    bit neg;
    p16 = 64'(pos) * 64'd16;
    neg = p16 < 64'(ctr);
    mag = neg ? 64'(ctr) - p16 : p16 - 64'(ctr);
    q   = (mag * 64'(inv) * 64'(depth) + XY_ROUND) / XY_DIVISOR;
    if (neg) begin
      if (q > SAT_NEG) return 24'sh800000;
      return 24'(~q + 64'd1);
    end
    if (q > SAT_POS) return 24'sh7FFFFF;
    return 24'(q);
  endfunction

  // Expected point for one accepted pixel if it is kept, then the raster advance
  task automatic predict_pixel(input logic [15:0] depth, input logic start);
    point_t p;
    int c, r;
    if (start) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (is_kept(depth)) begin
      p.x   = back_project(col_pos, cx_q4, fx_inv, depth);
      p.y   = back_project(row_pos, cy_q4, fy_inv, depth);
      p.z   = 23'((64'(depth) * 64'd65536 + Z_ROUND) / MM_PER_M);
      p.col = col_pos;
      p.row = row_pos;
      point_q.insert(point_q.size(), p);
    end
    c = int'(col_pos) + 1;
    r = int'(row_pos);
    if (c >= eff_dim(fw) || c > 'hFFF) begin
      c = 0;
      r = r + 1;
      if (r >= eff_dim(fh) || r > 'hFFF) r = 0;
    end
    col_pos = 12'(c);
    row_pos = 12'(r);
  endtask

  // Pixel driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    pixel_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      depth_mm_i    <= '0;
      frame_start_i <= 1'b0;
      burst_left    = 0;
      gap_left      = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_pixel(depth_mm_i, frame_start_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          depth_mm_i    <= nxt.depth;
          frame_start_i <= nxt.start;
          in_valid_i    <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Point receiver: stall pattern in modes, plus one long hold-off on request
  int rx_mode   = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_mode     = 0;
      mode_left   = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Point checker
  always @(posedge clk_i) begin : check_points
    point_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {point_x_o, point_y_o, point_z_o, pixel_col_o, pixel_row_o};
      if (point_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected point: x=%0d y=%0d z=%0d col=%0d row=%0d",
                   got.x, got.y, got.z, got.col, got.row);
        fail_count++;
      end else begin
        want = point_q.pop_front();
        if (got !== want) begin
          if (fail_count < MAX_REPORTS)
            $display("point mismatch: exp x=%0d y=%0d z=%0d col=%0d row=%0d, got x=%0d y=%0d z=%0d col=%0d row=%0d",
                     want.x, want.y, want.z, want.col, want.row,
                     got.x, got.y, got.z, got.col, got.row);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_pixel(input logic [15:0] depth, input logic start);
    pixel_t px;
    px.depth = depth;
    px.start = start;
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // One register request; valid stays high for a following request
  task automatic put_reg(input logic [dpc_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dpc_pkg::CFG_INV_FX:   fx_inv  = data;
      dpc_pkg::CFG_INV_FY:   fy_inv  = data;
      dpc_pkg::CFG_CENTER_X: cx_q4   = data[15:0];
      dpc_pkg::CFG_CENTER_Y: cy_q4   = data[15:0];
      dpc_pkg::CFG_DLIMIT:   z_limit = data[16:0];
      dpc_pkg::CFG_WIDTH:    fw      = data[12:0];
      dpc_pkg::CFG_HEIGHT:   fh      = data[12:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [23:0] fx, input logic [23:0] fy,
                              input logic [23:0] cx, input logic [23:0] cy,
                              input logic [23:0] lim, input logic [23:0] w,
                              input logic [23:0] h, input bit poke_unused);
    put_reg(dpc_pkg::CFG_INV_FX, fx);
    put_reg(dpc_pkg::CFG_INV_FY, fy);
    put_reg(dpc_pkg::CFG_CENTER_X, cx);
    put_reg(dpc_pkg::CFG_CENTER_Y, cy);
    put_reg(dpc_pkg::CFG_DLIMIT, lim);
    put_reg(dpc_pkg::CFG_WIDTH, w);
    put_reg(dpc_pkg::CFG_HEIGHT, h);
    if (poke_unused) put_reg(CFG_UNUSED, 24'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pixel is taken and every point is out, then let
  // any dropped pixel still in flight clear
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid_i || point_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(0, 3))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(1, 24'hFFFFFF));
      default: return 24'($urandom_range(8000, 200000));
    endcase
  endfunction

  // Center in Q12.4, junk in the bits above the register
  function automatic logic [23:0] pick_center(input int span);
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = 16'($urandom);
      default: v = 16'($urandom_range(0, 16 * span));
    endcase
    return {8'($urandom), v};
  endfunction

  function automatic logic [23:0] pick_dim(input int hi);
    logic [12:0] v;
    case ($urandom_range(0, 9))
      0:       v = 13'd0;
      1:       v = 13'(DIM_MAX);
      2:       v = 13'($urandom_range(DIM_MAX + 1, 8191));
      default: v = 13'($urandom_range(1, hi));
    endcase
    return {11'($urandom), v};
  endfunction

  function automatic logic [23:0] pick_limit();
    logic [16:0] v;
    case ($urandom_range(0, 11))
      0:          v = 17'd0;
      1:          v = 17'd65535;
      2:          v = 17'd65536;
      3:          v = 17'h1FFFF;
      4, 5, 6, 7: v = 17'($urandom_range(1, 65536));
      default:    v = 17'd65536;
    endcase
    return {7'($urandom), v};
  endfunction

  // Depth mix: markers, limit edges, small and full-range values
  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 15))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      2:       return 16'hFFFE;
      3:       return (z_limit == 17'd0) ? 16'h0000 : 16'(z_limit - 17'd1);
      4:       return (z_limit > 17'd65535) ? 16'($urandom) : 16'(z_limit);
      5, 6:    return 16'($urandom_range(0, 1023));
      default: return (z_limit == 17'd0) ? 16'($urandom) : 16'($urandom_range(0, z_limit - 1));
    endcase
  endfunction

  initial begin : stimulus
    int pos, frame_len, n;
    bit start;
    logic [15:0] d;

    rst_ni <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: depth extremes, missing pixel, restart mid-row
    push_pixel(16'd0, 1'b1);
    push_pixel(dpc_pkg::NO_DEPTH, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd1, 1'b0);
    push_pixel(16'h5555, 1'b0);
    push_pixel(16'hAAAA, 1'b0);
    push_pixel(16'd1000, 1'b0);
    push_pixel(16'h8000, 1'b0);
    push_pixel(16'd2000, 1'b1);
    settle();

    // Largest reciprocal: positive saturation on x; limit at the marker value,
    // short frame so both counters wrap
    program_regs(24'hFFFFFF, 24'd1, 24'hFF0000, 24'hFFFFFF, 24'd65535, 24'd3, 24'd2, 1'b0);
    push_pixel(16'hFFFE, 1'b1);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd40000, 1'b0);
    push_pixel(dpc_pkg::NO_DEPTH, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd12345, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    settle();

    // Center at the far edge: negative saturation; limit above the marker
    program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hABFFFF, 24'h000000, 24'hFFFFFF, 24'd2, 24'd2, 1'b1);
    push_pixel(16'hFFFE, 1'b1);
    push_pixel(dpc_pkg::NO_DEPTH, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd1, 1'b0);
    settle();

    // Zero limit drops every pixel
    program_regs(24'd24935, 24'd24938, 24'd6392, 24'd4810, 24'd0, 24'd800, 24'd592, 1'b0);
    push_pixel(16'd0, 1'b1);
    push_pixel(16'd100, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    settle();

    // Receiver holds off while the sender keeps offering
    program_regs(24'd24935, 24'd24938, 24'd64, 24'd32, 24'd65536, 24'd8, 24'd4, 1'b0);
    for (int i = 0; i < 80; i++) push_pixel(16'($urandom_range(0, 65534)), i == 0);
    hold_arm <= 1'b1;
    settle();

    // Random frames under random settings
    while (rand_items < RAND_ITEM_GOAL) begin
      program_regs(pick_inv(), pick_inv(), pick_center(12), pick_center(6),
                   pick_limit(), pick_dim(12), pick_dim(6), $urandom_range(0, 3) == 0);
      frame_len = eff_dim(fw) * eff_dim(fh);
      pos  = 0;
      n    = 0;
      while (n < PHASE_ITEMS) begin
        // mostly well-formed frames, now and then a stray or missing start
        start = (pos == 0) ^ ($urandom_range(0, 39) == 0);
        if (start) pos = 0;
        pos = pos + 1;
        if (pos >= frame_len) pos = 0;
        d = pick_depth();
        push_pixel(d, start);
        n++;
      end
      rand_items += n;
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (point_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> depth_to_point_cloud.f
+incdir+rtl/core
rtl/core/dpc_pkg.sv
rtl/core/dpc_datapath.sv
rtl/core/dpc_ctrl.sv
rtl/core/depth_to_point_cloud.sv
tb/tb.sv
